// ===== sv/kdq_pkg.sv =====
// shared types and constants for the keyframe-aware drop queue
package kdq_pkg;

  localparam int STAMP_W    = 63;
  localparam int HANDLE_W   = 16;
  localparam int LIMIT_W    = 7;
  localparam int SPAN_W     = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int FILL_W     = 8;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_LIVE_LQ  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOFT_LIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HARD_LIM = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPAN = 2'd3;

  localparam logic               RST_LIVE_LQ  = 1'b0;
  localparam logic [LIMIT_W-1:0] RST_SOFT_LIM = 7'd12;
  localparam logic [LIMIT_W-1:0] RST_HARD_LIM = 7'd120;
  localparam logic [SPAN_W-1:0]  RST_MIN_SPAN = 32'd2000000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUSH_WR,
    ST_PUSH_CHK,
    ST_SCAN,
    ST_SPAN,
    ST_DECIDE,
    ST_CUT,
    ST_CUT_WR,
    ST_TRIM,
    ST_POP_RD,
    ST_POP_OUT,
    ST_DONE
  } kdq_state_t;

  typedef struct packed {
    logic capture;
    logic push_wr;
    logic scan_start;
    logic scan_run;
    logic span_calc;
    logic cut;
    logic cut_wr;
    logic trim;
    logic pop_rd;
    logic pop_out;
    logic load;
  } kdq_cmd_t;

  typedef struct packed {
    logic in_pop;
    logic count_zero;
    logic over_limit;
    logic scan_done;
    logic cut_go;
    logic out_free;
  } kdq_stat_t;

endpackage

// ===== sv/kdq_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
module kdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/kdq_ctrl.sv =====
// sequencer for push, scan, cut, trim and pop of the drop queue
module kdq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  kdq_pkg::kdq_stat_t stat,
  output kdq_pkg::kdq_cmd_t  cmd
);
  import kdq_pkg::*;

  kdq_state_t state;
  kdq_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = stat.in_pop ? ST_POP_RD : ST_PUSH_WR;
        end
      end
      ST_PUSH_WR:  state_next = ST_PUSH_CHK;
      ST_PUSH_CHK: state_next = stat.over_limit ? ST_SCAN : ST_TRIM;
      ST_SCAN: begin
        if (stat.scan_done) begin
          state_next = ST_SPAN;
        end
      end
      ST_SPAN:     state_next = ST_DECIDE;
      ST_DECIDE:   state_next = stat.cut_go ? ST_CUT : ST_TRIM;
      ST_CUT:      state_next = ST_CUT_WR;
      ST_CUT_WR:   state_next = ST_TRIM;
      ST_TRIM:     state_next = ST_DONE;
      ST_POP_RD:   state_next = stat.count_zero ? ST_DONE : ST_POP_OUT;
      ST_POP_OUT:  state_next = ST_DONE;
      ST_DONE: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_PUSH_WR:  cmd.push_wr    = 1'b1;
      ST_PUSH_CHK: cmd.scan_start = 1'b1;
      ST_SCAN:     cmd.scan_run   = 1'b1;
      ST_SPAN:     cmd.span_calc  = 1'b1;
      ST_DECIDE:   cmd            = '0;
      ST_CUT:      cmd.cut        = 1'b1;
      ST_CUT_WR:   cmd.cut_wr     = 1'b1;
      ST_TRIM:     cmd.trim       = 1'b1;
      ST_POP_RD:   cmd.pop_rd     = 1'b1;
      ST_POP_OUT:  cmd.pop_out    = 1'b1;
      ST_DONE:     cmd.load       = stat.out_free;
      default:     cmd            = '0;
    endcase
  end

endmodule

// ===== sv/kdq_dp.sv =====
// queue pointers, scan trackers, config registers and result register
module kdq_dp #(
  parameter int DEPTH    = 128,
  parameter int TAG_BITS = 16,
  localparam int AW      = $clog2(DEPTH),
  localparam int ENTRY_W = kdq_pkg::STAMP_W + TAG_BITS + 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  kdq_pkg::kdq_cmd_t               cmd,
  output kdq_pkg::kdq_stat_t              stat,
  input  logic                            cfg_we,
  input  logic [kdq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kdq_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            req_type,
  input  logic                            is_key,
  input  logic                            is_low_quality,
  input  logic                            is_video,
  input  logic [kdq_pkg::STAMP_W-1:0]     stamp,
  input  logic [kdq_pkg::HANDLE_W-1:0]    handle,
  output logic                            ram_we,
  output logic [AW-1:0]                   ram_waddr,
  output logic [ENTRY_W-1:0]              ram_wdata,
  output logic [AW-1:0]                   ram_raddr,
  input  logic [ENTRY_W-1:0]              ram_rdata,
  output logic                            res_valid,
  input  logic                            res_stall,
  output logic                            out_valid,
  output logic                            out_key,
  output logic                            out_low_quality,
  output logic                            out_video,
  output logic                            out_after_drop,
  output logic [kdq_pkg::STAMP_W-1:0]     out_stamp,
  output logic [kdq_pkg::HANDLE_W-1:0]    out_handle,
  output logic                            drop_report,
  output logic [kdq_pkg::FILL_W-1:0]      fill,
  output logic [kdq_pkg::FILL_W-1:0]      dropped_count
);
  import kdq_pkg::*;

  localparam int CW      = $clog2(DEPTH + 1);
  localparam int LW      = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam int SW      = (CW + 1 > FILL_W + 1) ? CW + 1 : FILL_W + 1;
  localparam int TAG_LSB = STAMP_W;
  localparam int KEY_BIT = STAMP_W + TAG_BITS;
  localparam int LQ_BIT  = KEY_BIT + 1;
  localparam int VID_BIT = KEY_BIT + 2;
  localparam int AD_BIT  = KEY_BIT + 3;
  localparam int SPAN_FW = STAMP_W + 1;

  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base, input logic [CW-1:0] off);
    logic [CW:0] sum;
    begin
      sum = (CW + 1)'(base) + (CW + 1)'(off);
      if (sum >= (CW + 1)'(DEPTH)) begin
        sum = sum - (CW + 1)'(DEPTH);
      end
      return sum[AW-1:0];
    end
  endfunction

  // config registers
  logic               live_lq;
  logic [LIMIT_W-1:0] soft_lim;
  logic [LIMIT_W-1:0] hard_lim;
  logic [SPAN_W-1:0]  min_span;

  // queue state
  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic          pending;
  logic [CW:0]   dropped;

  // captured input beat
  logic                key_q;
  logic                lq_q;
  logic                vid_q;
  logic [STAMP_W-1:0]  stamp_q;
  logic [HANDLE_W-1:0] handle_q;

  // scan
  logic [CW-1:0]      rd_idx;
  logic               pipe_v;
  logic [AW-1:0]      pipe_idx;
  logic               fq_found;
  logic [STAMP_W-1:0] fq_first;
  logic [STAMP_W-1:0] fq_last;
  logic               lq_found;
  logic [STAMP_W-1:0] lq_first;
  logic [STAMP_W-1:0] lq_last;
  logic               m_found;
  logic [AW-1:0]      m_idx;
  logic               a_found;
  logic [AW-1:0]      a_idx;
  logic [SPAN_FW-1:0] span;

  // pop result
  logic               pop_hit;
  logic               rep;
  logic [ENTRY_W-1:0] entry;

  logic                full;
  logic [AW-1:0]       tail;
  logic [TAG_BITS-1:0] h_tag;
  logic [HANDLE_W+31:0] h_wide;
  logic [TAG_BITS+HANDLE_W-1:0] o_wide;
  logic [ENTRY_W-1:0]  push_word;
  logic [ENTRY_W-1:0]  cut_word;
  logic [LW-1:0]       cnt_l;
  logic [LW-1:0]       hard_l;
  logic [LW-1:0]       soft_l;
  logic [LW-1:0]       trim_diff;
  logic                over_hard;
  logic                over_soft;
  logic                scan_issue;
  logic [AW-1:0]       cut_idx;
  logic                span_hit;
  logic                e_key;
  logic                e_lq;
  logic                e_vid;
  logic [STAMP_W-1:0]  e_stamp;
  logic [SPAN_FW-1:0]  sp_last;
  logic [SPAN_FW-1:0]  sp_first;
  logic [SW-1:0]       cnt_sat;
  logic [SW-1:0]       drp_sat;

  assign full      = (count == CW'(DEPTH));
  assign tail      = full ? head : wrap(head, count);
  assign h_wide    = {32'd0, handle_q};
  assign h_tag     = h_wide[TAG_BITS-1:0];
  assign push_word = {1'b0, vid_q, lq_q, key_q, h_tag, stamp_q};

  always_comb begin
    cut_word         = ram_rdata;
    cut_word[AD_BIT] = 1'b1;
  end

  assign cnt_l     = LW'(count);
  assign hard_l    = LW'(hard_lim);
  assign soft_l    = LW'(soft_lim);
  assign over_hard = cnt_l > hard_l;
  assign over_soft = cnt_l > soft_l;
  assign trim_diff = cnt_l - hard_l;

  assign scan_issue = cmd.scan_run && (rd_idx < count);
  assign cut_idx    = m_found ? m_idx : a_idx;
  assign span_hit   = $signed(span) > $signed(SPAN_FW'(min_span));

  assign e_key   = ram_rdata[KEY_BIT];
  assign e_lq    = ram_rdata[LQ_BIT];
  assign e_vid   = ram_rdata[VID_BIT];
  assign e_stamp = ram_rdata[STAMP_W-1:0];

  always_comb begin
    if (fq_found) begin
      sp_last  = SPAN_FW'(fq_last);
      sp_first = SPAN_FW'(fq_first);
    end else if (lq_found) begin
      sp_last  = SPAN_FW'(lq_last);
      sp_first = SPAN_FW'(lq_first);
    end else begin
      sp_last  = '0;
      sp_first = '0;
    end
  end

  assign stat.in_pop     = (req_type == REQ_POP);
  assign stat.count_zero = (count == '0);
  assign stat.over_limit = over_hard || over_soft;
  assign stat.scan_done  = !pipe_v && (rd_idx == count);
  assign stat.cut_go     = (over_hard || (over_soft && span_hit)) && (m_found || a_found);
  assign stat.out_free   = !res_valid || !res_stall;

  assign ram_we    = cmd.push_wr || cmd.cut_wr;
  assign ram_waddr = cmd.push_wr ? tail : head;
  assign ram_wdata = cmd.push_wr ? push_word : cut_word;

  always_comb begin
    if (cmd.scan_run) begin
      ram_raddr = wrap(head, rd_idx);
    end else if (cmd.cut) begin
      ram_raddr = wrap(head, CW'(cut_idx));
    end else begin
      ram_raddr = head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live_lq  <= RST_LIVE_LQ;
      soft_lim <= RST_SOFT_LIM;
      hard_lim <= RST_HARD_LIM;
      min_span <= RST_MIN_SPAN;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LIVE_LQ:  live_lq  <= cfg_data[0];
        CFG_SOFT_LIM: soft_lim <= cfg_data[LIMIT_W-1:0];
        CFG_HARD_LIM: hard_lim <= cfg_data[LIMIT_W-1:0];
        CFG_MIN_SPAN: min_span <= cfg_data[SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      key_q    <= is_key;
      lq_q     <= is_low_quality;
      vid_q    <= is_video;
      stamp_q  <= stamp;
      handle_q <= handle;
    end
  end

  // queue pointers and pending report
  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      count   <= '0;
      pending <= 1'b0;
    end else begin
      if (cmd.push_wr) begin
        if (full) begin
          head <= wrap(head, CW'(1));
        end else begin
          count <= count + CW'(1);
        end
      end
      if (cmd.cut) begin
        head  <= wrap(head, CW'(cut_idx));
        count <= count - CW'(cut_idx);
      end
      if (cmd.cut_wr) begin
        pending <= 1'b1;
      end
      if (cmd.trim && over_hard) begin
        head  <= wrap(head, trim_diff[CW-1:0]);
        count <= hard_l[CW-1:0];
      end
      if (cmd.pop_out) begin
        head    <= wrap(head, CW'(1));
        count   <= count - CW'(1);
        pending <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      dropped <= '0;
      pop_hit <= 1'b0;
      rep     <= 1'b0;
    end
    if (cmd.push_wr) begin
      dropped <= (CW + 1)'(full);
    end
    if (cmd.cut) begin
      dropped <= dropped + (CW + 1)'(cut_idx);
    end
    if (cmd.trim && over_hard) begin
      dropped <= dropped + (CW + 1)'(trim_diff[CW-1:0]);
    end
    if (cmd.pop_out) begin
      pop_hit <= 1'b1;
      rep     <= pending;
      entry   <= ram_rdata;
    end
  end

  // one read issued per cycle, data tracked in the cycle after it is issued
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_v <= 1'b0;
    end else if (cmd.scan_start) begin
      pipe_v <= 1'b0;
    end else if (cmd.scan_run) begin
      pipe_v <= scan_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      rd_idx   <= '0;
      fq_found <= 1'b0;
      lq_found <= 1'b0;
      m_found  <= 1'b0;
      a_found  <= 1'b0;
    end else if (cmd.scan_run) begin
      if (scan_issue) begin
        rd_idx   <= rd_idx + CW'(1);
        pipe_idx <= rd_idx[AW-1:0];
      end
      if (pipe_v) begin
        if (e_vid && !e_lq) begin
          if (!fq_found) begin
            fq_first <= e_stamp;
          end
          fq_last  <= e_stamp;
          fq_found <= 1'b1;
        end
        if (e_vid && e_lq) begin
          if (!lq_found) begin
            lq_first <= e_stamp;
          end
          lq_last  <= e_stamp;
          lq_found <= 1'b1;
        end
        if (e_key) begin
          a_idx   <= pipe_idx;
          a_found <= 1'b1;
        end
        if (e_key && (e_lq == live_lq)) begin
          m_idx   <= pipe_idx;
          m_found <= 1'b1;
        end
      end
    end
    if (cmd.span_calc) begin
      span <= sp_last - sp_first;
    end
  end

  // result register
  assign cnt_sat = SW'(count);
  assign drp_sat = SW'(dropped);
  assign o_wide  = {{HANDLE_W{1'b0}}, entry[KEY_BIT-1:TAG_LSB]};

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_valid       <= pop_hit;
      out_key         <= pop_hit & entry[KEY_BIT];
      out_low_quality <= pop_hit & entry[LQ_BIT];
      out_video       <= pop_hit & entry[VID_BIT];
      out_after_drop  <= pop_hit & entry[AD_BIT];
      out_stamp       <= pop_hit ? entry[STAMP_W-1:0] : '0;
      out_handle      <= pop_hit ? o_wide[HANDLE_W-1:0] : '0;
      drop_report     <= rep;
      fill            <= (cnt_sat > SW'(255)) ? {FILL_W{1'b1}} : cnt_sat[FILL_W-1:0];
      dropped_count   <= (drp_sat > SW'(255)) ? {FILL_W{1'b1}} : drp_sat[FILL_W-1:0];
    end
  end

endmodule

// ===== sv/keyframe_aware_drop_queue_unit.sv =====
// Keyframe-aware drop queue: a FIFO of media packet descriptors held in one RAM
// (DEPTH entries, stamp, tag and flag bits per entry). While the fill stays at or
// below both limits a push skips the scan; above either limit the block walks the
// whole queue through the RAM read port, one entry per cycle, to find the video
// span and the newest keyframes, and may then cut at a keyframe. The input is taken
// again as soon as the result sits in the output register, even while that register
// is stalled.
module keyframe_aware_drop_queue_unit #(
  parameter int DEPTH    = 128,
  parameter int TAG_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [kdq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kdq_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           req_type,
  input  logic                           is_key,
  input  logic                           is_low_quality,
  input  logic                           is_video,
  input  logic [kdq_pkg::STAMP_W-1:0]    stamp,
  input  logic [kdq_pkg::HANDLE_W-1:0]   handle,
  output logic                           res_valid,
  input  logic                           res_stall,
  output logic                           out_valid,
  output logic                           out_key,
  output logic                           out_low_quality,
  output logic                           out_video,
  output logic                           out_after_drop,
  output logic [kdq_pkg::STAMP_W-1:0]    out_stamp,
  output logic [kdq_pkg::HANDLE_W-1:0]   out_handle,
  output logic                           drop_report,
  output logic [kdq_pkg::FILL_W-1:0]     fill,
  output logic [kdq_pkg::FILL_W-1:0]     dropped_count
);
  import kdq_pkg::*;

  localparam int AW      = $clog2(DEPTH);
  localparam int ENTRY_W = STAMP_W + TAG_BITS + 4;
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'((DEPTH > 255) ? 255 : DEPTH);

  kdq_cmd_t  cmd;
  kdq_stat_t stat;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  kdq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  kdq_dp #(
    .DEPTH    (DEPTH),
    .TAG_BITS (TAG_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .req_type        (req_type),
    .is_key          (is_key),
    .is_low_quality  (is_low_quality),
    .is_video        (is_video),
    .stamp           (stamp),
    .handle          (handle),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata),
    .res_valid       (res_valid),
    .res_stall       (res_stall),
    .out_valid       (out_valid),
    .out_key         (out_key),
    .out_low_quality (out_low_quality),
    .out_video       (out_video),
    .out_after_drop  (out_after_drop),
    .out_stamp       (out_stamp),
    .out_handle      (out_handle),
    .drop_report     (drop_report),
    .fill            (fill),
    .dropped_count   (dropped_count)
  );

  kdq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // an accepted beat always starts work, so the input stalls next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accept");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (fill <= FILL_MAX))
    else $error("fill above queue depth");

  a_report_needs_entry: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !out_valid) |-> !drop_report)
    else $error("drop report without popped entry");

  a_pop_drops_nothing: assert property (@(posedge clk) disable iff (rst)
    (res_valid && out_valid) |-> (dropped_count == '0))
    else $error("pop reported discarded entries");

endmodule

// ===== test/tb.sv =====
// self-checking testbench for the keyframe-aware drop queue
module tb;
  import kdq_pkg::*;

  localparam int QDEPTH      = 128;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int HOLD_CYCLES = 600;
  localparam int TAIL_CYCLES = 200;
  localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};

  typedef struct packed {
    logic                req;
    logic                key;
    logic                lq;
    logic                video;
    logic [STAMP_W-1:0]  stamp;
    logic [HANDLE_W-1:0] handle;
  } beat_t;

  typedef struct packed {
    logic                valid;
    logic                key;
    logic                lq;
    logic                video;
    logic                after;
    logic [STAMP_W-1:0]  stamp;
    logic [HANDLE_W-1:0] handle;
    logic                report;
    logic [FILL_W-1:0]   fill;
    logic [FILL_W-1:0]   dropped;
  } res_t;

  typedef struct packed {
    logic                key;
    logic                lq;
    logic                video;
    logic                after;
    logic [HANDLE_W-1:0] handle;
  } tag_t;

  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    beat_t                 beat;
    bit                    lit;
    res_t                  want;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  req_type = REQ_PUSH;
  logic                  is_key = 1'b0;
  logic                  is_low_quality = 1'b0;
  logic                  is_video = 1'b0;
  logic [STAMP_W-1:0]    stamp = '0;
  logic [HANDLE_W-1:0]   handle = '0;
  logic                  res_valid;
  logic                  res_stall = 1'b0;
  logic                  out_valid;
  logic                  out_key;
  logic                  out_low_quality;
  logic                  out_video;
  logic                  out_after_drop;
  logic [STAMP_W-1:0]    out_stamp;
  logic [HANDLE_W-1:0]   out_handle;
  logic                  drop_report;
  logic [FILL_W-1:0]     fill;
  logic [FILL_W-1:0]     dropped_count;

  keyframe_aware_drop_queue_unit uut (.*);

  always #5 clk = ~clk;

  // predictor copy of the queue and its registers
  logic [STAMP_W-1:0] q_stamp [QDEPTH];
  tag_t               q_tag [QDEPTH];
  int                 q_head;
  int                 q_count;
  bit                 q_report;
  logic               m_live;
  int                 m_soft;
  int                 m_hard;
  longint             m_span;

  res_t awaited_res [$];
  row_t directed_rows [$];
  int   errors = 0;
  int   res_count = 0;
  int   cycle_count = 0;
  int   hold_token = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   stall_left = 0;
  int   rx_calm = 0;

  logic [STAMP_W-1:0] stream_stamp [2];
  int                 gop_left [2];

  function automatic int slot_of(int i);
    return (q_head + i) % QDEPTH;
  endfunction

  function automatic void discard_front(int n);
    if (n > q_count) n = q_count;
    q_head = (q_head + n) % QDEPTH;
    q_count -= n;
  endfunction

  function automatic bit video_edges(bit want_lq, output longint span);
    longint first, last, s;
    bit found;
    tag_t t;
    found = 1'b0;
    first = 0;
    last = 0;
    for (int i = 0; i < q_count; i++) begin
      t = q_tag[slot_of(i)];
      if (t.video && t.lq == want_lq) begin
        s = longint'({1'b0, q_stamp[slot_of(i)]});
        if (!found) first = s;
        last = s;
        found = 1'b1;
      end
    end
    span = last - first;
    return found;
  endfunction

  function automatic bit cut_at_key(bit match_q, inout int dropped);
    tag_t t;
    for (int i = q_count - 1; i >= 0; i--) begin
      t = q_tag[slot_of(i)];
      if (t.key && (!match_q || t.lq == m_live)) begin
        dropped += i;
        discard_front(i);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic res_t drop_queue_step(beat_t b);
    res_t   r;
    tag_t   t;
    int     dropped;
    int     h;
    bit     cut;
    longint span;
    r = '0;
    dropped = 0;
    if (b.req == REQ_POP) begin
      if (q_count > 0) begin
        h = slot_of(0);
        t = q_tag[h];
        r.valid = 1'b1;
        r.key = t.key;
        r.lq = t.lq;
        r.video = t.video;
        r.after = t.after;
        r.stamp = q_stamp[h];
        r.handle = t.handle;
        r.report = q_report;
        q_report = 1'b0;
        discard_front(1);
      end
    end else begin
      if (q_count >= QDEPTH) begin
        discard_front(1);
        dropped++;
      end
      h = slot_of(q_count);
      q_stamp[h] = b.stamp;
      q_tag[h] = '{key: b.key, lq: b.lq, video: b.video, after: 1'b0, handle: b.handle};
      q_count++;
      // full quality span first, low quality as fallback
      span = 0;
      if (!video_edges(1'b0, span)) void'(video_edges(1'b1, span));
      if (q_count > m_hard || (q_count > m_soft && span > m_span)) begin
        cut = cut_at_key(1'b1, dropped);
        if (!cut) cut = cut_at_key(1'b0, dropped);
        if (cut) begin
          q_tag[slot_of(0)].after = 1'b1;
          q_report = 1'b1;
        end
      end
      if (q_count > m_hard) begin
        dropped += q_count - m_hard;
        discard_front(q_count - m_hard);
      end
      r.dropped = FILL_W'(dropped > 255 ? 255 : dropped);
    end
    r.fill = FILL_W'(q_count > 255 ? 255 : q_count);
    return r;
  endfunction

  function automatic beat_t mk_push(logic k, logic lq, logic v, logic [STAMP_W-1:0] st,
                                    logic [HANDLE_W-1:0] h);
    return '{req: REQ_PUSH, key: k, lq: lq, video: v, stamp: st, handle: h};
  endfunction

  function automatic beat_t mk_pop();
    beat_t b;
    b.req = REQ_POP;
    b.key = 1'($urandom_range(0, 1));
    b.lq = 1'($urandom_range(0, 1));
    b.video = 1'($urandom_range(0, 1));
    b.stamp = STAMP_W'({$urandom(), $urandom()});
    b.handle = HANDLE_W'($urandom());
    return b;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // mostly gop-shaped streams of both qualities, with some audio and noise beats
  function automatic beat_t gen_beat(int push_pct);
    beat_t b;
    int    s;
    b = mk_pop();
    if ($urandom_range(0, 99) < 8) begin
      b.req = 1'($urandom_range(0, 1));
      return b;
    end
    if ($urandom_range(0, 99) >= push_pct) return b;
    b.req = REQ_PUSH;
    s = ($urandom_range(0, 99) < 70) ? 0 : 1;
    b.lq = 1'(s);
    stream_stamp[s] += STAMP_W'($urandom_range(15000, 45000));
    if ($urandom_range(0, 99) < 3) stream_stamp[s] -= STAMP_W'($urandom_range(0, 3000000));
    b.stamp = stream_stamp[s];
    if ($urandom_range(0, 99) < 15) begin
      b.video = 1'b0;
      b.key = 1'b0;
    end else begin
      b.video = 1'b1;
      if (gop_left[s] == 0) begin
        b.key = 1'b1;
        gop_left[s] = $urandom_range(2, 30);
      end else begin
        b.key = 1'b0;
        gop_left[s]--;
      end
    end
    return b;
  endfunction

  task automatic add_beat(beat_t b, bit lit = 1'b0, res_t want = '0);
    row_t rw;
    rw.is_cfg = 1'b0;
    rw.idx = '0;
    rw.data = '0;
    rw.beat = b;
    rw.lit = lit;
    rw.want = want;
    directed_rows.push_back(rw);
  endtask

  task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    row_t rw;
    rw.is_cfg = 1'b1;
    rw.idx = idx;
    rw.data = data;
    rw.beat = '0;
    rw.lit = 1'b0;
    rw.want = '0;
    directed_rows.push_back(rw);
  endtask

  task automatic report_mismatch(string msg);
    $display("mismatch at result %0d: %s", res_count, msg);
    errors++;
  endtask

  task automatic send_beat(beat_t b, bit lit, res_t want);
    res_t r;
    in_valid <= 1'b1;
    req_type <= b.req;
    is_key <= b.key;
    is_low_quality <= b.lq;
    is_video <= b.video;
    stamp <= b.stamp;
    handle <= b.handle;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = drop_queue_step(b);
    awaited_res.push_back(lit ? want : r);
  endtask

  task automatic pause_sender(int g);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (awaited_res.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      CFG_LIVE_LQ:  m_live = data[0];
      CFG_SOFT_LIM: m_soft = int'(data[LIMIT_W-1:0]);
      CFG_HARD_LIM: m_hard = int'(data[LIMIT_W-1:0]);
      CFG_MIN_SPAN: m_span = longint'({32'd0, data[SPAN_W-1:0]});
      default: ;
    endcase
  endtask

  // unused upper data bits get random junk
  task automatic apply_config(logic live, logic [LIMIT_W-1:0] soft_cap,
                              logic [LIMIT_W-1:0] hard, logic [SPAN_W-1:0] span);
    logic [CFG_DATA_W-1:0] junk;
    junk = $urandom();
    write_reg(CFG_LIVE_LQ, {junk[CFG_DATA_W-1:1], live});
    junk = $urandom();
    write_reg(CFG_SOFT_LIM, {junk[CFG_DATA_W-1:LIMIT_W], soft_cap});
    junk = $urandom();
    write_reg(CFG_HARD_LIM, {junk[CFG_DATA_W-1:LIMIT_W], hard});
    write_reg(CFG_MIN_SPAN, span);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: check each beat, then pick the stall for the next cycle
  always @(posedge clk) begin
    res_t got;
    res_t want;
    int   g;
    if (!rst && res_valid && !res_stall) begin
      got = {out_valid, out_key, out_low_quality, out_video, out_after_drop, out_stamp,
             out_handle, drop_report, fill, dropped_count};
      if (awaited_res.size() == 0) begin
        report_mismatch("result beat with nothing awaited");
      end else begin
        want = awaited_res.pop_front();
        if (got.valid !== want.valid)
          report_mismatch($sformatf("out_valid %0h, expected %0h", got.valid, want.valid));
        if (got.key !== want.key)
          report_mismatch($sformatf("out_key %0h, expected %0h", got.key, want.key));
        if (got.lq !== want.lq)
          report_mismatch($sformatf("out_low_quality %0h, expected %0h", got.lq, want.lq));
        if (got.video !== want.video)
          report_mismatch($sformatf("out_video %0h, expected %0h", got.video, want.video));
        if (got.after !== want.after)
          report_mismatch($sformatf("out_after_drop %0h, expected %0h", got.after, want.after));
        if (got.stamp !== want.stamp)
          report_mismatch($sformatf("out_stamp %0h, expected %0h", got.stamp, want.stamp));
        if (got.handle !== want.handle)
          report_mismatch($sformatf("out_handle %0h, expected %0h", got.handle, want.handle));
        if (got.report !== want.report)
          report_mismatch($sformatf("drop_report %0h, expected %0h", got.report, want.report));
        if (got.fill !== want.fill)
          report_mismatch($sformatf("fill %0d, expected %0d", got.fill, want.fill));
        if (got.dropped !== want.dropped)
          report_mismatch($sformatf("dropped_count %0d, expected %0d", got.dropped,
                                    want.dropped));
      end
      res_count++;
    end
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      res_stall <= 1'b1;
    end else if (rx_calm > 0) begin
      rx_calm--;
      res_stall <= 1'b0;
    end else begin
      g = gap_len();
      if (g > 0) begin
        stall_left = g - 1;
        res_stall <= 1'b1;
      end else begin
        res_stall <= 1'b0;
        if ($urandom_range(0, 99) < 3) rx_calm = $urandom_range(20, 150);
      end
    end
  end

  initial begin
    res_t             w;
    int               items;
    int               push_pct;
    int               press;
    int               tx_calm;
    int               g;
    logic             live;
    logic [LIMIT_W-1:0] soft_cap;
    logic [LIMIT_W-1:0] hard;
    logic [SPAN_W-1:0]  span;

    m_live = RST_LIVE_LQ;
    m_soft = int'(RST_SOFT_LIM);
    m_hard = int'(RST_HARD_LIM);
    m_span = longint'({32'd0, RST_MIN_SPAN});
    q_head = 0;
    q_count = 0;
    q_report = 1'b0;
    stream_stamp[0] = 63'd1000;
    stream_stamp[1] = 63'd5000;
    gop_left[0] = 0;
    gop_left[1] = 0;
    tx_calm = 0;

    // extremes right after reset
    w = '0;
    add_beat(mk_pop(), 1'b1, w);
    w = '0;
    w.fill = 8'd1;
    add_beat(mk_push(1'b1, 1'b0, 1'b1, STAMP_MAX, 16'hFFFF), 1'b1, w);
    w = '0;
    w.valid = 1'b1;
    w.key = 1'b1;
    w.video = 1'b1;
    w.stamp = STAMP_MAX;
    w.handle = 16'hFFFF;
    add_beat(mk_pop(), 1'b1, w);
    w = '0;
    w.fill = 8'd1;
    add_beat(mk_push(1'b0, 1'b1, 1'b0, 63'd0, 16'd0), 1'b1, w);
    w = '0;
    w.valid = 1'b1;
    w.lq = 1'b1;
    add_beat(mk_pop(), 1'b1, w);
    add_cfg(CFG_LIVE_LQ, 32'd1);
    add_cfg(CFG_SOFT_LIM, 32'd2);
    add_cfg(CFG_HARD_LIM, 32'd3);
    add_cfg(CFG_MIN_SPAN, 32'd10);
    // cut prefers the keyframe of live quality
    add_beat(mk_push(1'b1, 1'b0, 1'b1, 63'd100, 16'd1));
    add_beat(mk_push(1'b1, 1'b1, 1'b1, 63'd200, 16'd2));
    add_beat(mk_push(1'b0, 1'b0, 1'b1, 63'd300, 16'd3));
    add_beat(mk_pop());
    add_beat(mk_pop());
    add_beat(mk_pop());
    // no live quality keyframe, cut falls back and lands on the head
    add_beat(mk_push(1'b1, 1'b0, 1'b1, 63'd1000, 16'd4));
    add_beat(mk_push(1'b0, 1'b0, 1'b1, 63'd1100, 16'd5));
    add_beat(mk_push(1'b0, 1'b0, 1'b1, 63'd1200, 16'd6));
    // trimming throws away the freshly marked head
    add_beat(mk_push(1'b0, 1'b0, 1'b1, 63'd1300, 16'd7));
    add_beat(mk_pop());
    add_cfg(CFG_SOFT_LIM, 32'd1);
    add_cfg(CFG_MIN_SPAN, 32'd0);
    add_beat(mk_push(1'b1, 1'b0, 1'b1, 63'd5000, 16'd8));
    add_beat(mk_pop());
    // span running backwards
    add_beat(mk_push(1'b0, 1'b0, 1'b1, 63'd9000, 16'd9));
    add_beat(mk_push(1'b0, 1'b0, 1'b1, 63'd8000, 16'd10));
    add_cfg(CFG_HARD_LIM, 32'd1);
    // no keyframe at all, trimming only
    add_beat(mk_push(1'b0, 1'b0, 1'b0, 63'd7000, 16'd11));
    add_cfg(CFG_SOFT_LIM, 32'd0);
    add_cfg(CFG_HARD_LIM, 32'd0);
    add_beat(mk_push(1'b1, 1'b1, 1'b1, 63'd100, 16'd12));
    // empty pop keeps the report pending
    w = '0;
    add_beat(mk_pop(), 1'b1, w);
    add_cfg(CFG_HARD_LIM, 32'd5);
    add_beat(mk_push(1'b0, 1'b0, 1'b1, 63'd50, 16'd13));
    add_beat(mk_pop());

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        if (i == 0 || !directed_rows[i-1].is_cfg) drain_results();
        write_reg(directed_rows[i].idx, directed_rows[i].data);
        if (i + 1 == directed_rows.size() || !directed_rows[i+1].is_cfg) cfg_we <= 1'b0;
      end else begin
        send_beat(directed_rows[i].beat, directed_rows[i].lit, directed_rows[i].want);
        pause_sender(gap_len());
      end
    end

    for (int p = 0; p < 8; p++) begin
      items = 140;
      push_pct = 65;
      press = 0;
      case (p)
        0: begin
          live = RST_LIVE_LQ;
          soft_cap = RST_SOFT_LIM;
          hard = RST_HARD_LIM;
          span = RST_MIN_SPAN;
        end
        1: begin
          live = 1'b1;
          soft_cap = 7'd4;
          hard = 7'd16;
          span = 32'd50000;
          push_pct = 60;
        end
        2: begin
          // long receiver hold-off while the sender keeps going
          live = 1'b0;
          soft_cap = 7'd127;
          hard = 7'd127;
          span = 32'd0;
          items = 200;
          push_pct = 90;
          press = 40;
        end
        3: begin
          live = 1'($urandom_range(0, 1));
          soft_cap = 7'd1;
          hard = 7'd1;
          span = 32'd0;
          push_pct = 50;
        end
        4: begin
          live = 1'b1;
          soft_cap = 7'd0;
          hard = 7'd0;
          span = $urandom();
          items = 30;
          push_pct = 60;
        end
        5: begin
          live = 1'b0;
          soft_cap = 7'd2;
          hard = 7'd40;
          span = 32'hFFFF_FFFF;
        end
        default: begin
          live = 1'($urandom_range(0, 1));
          soft_cap = 7'($urandom_range(1, 127));
          hard = 7'($urandom_range(1, 127));
          span = $urandom_range(0, 3000000);
          push_pct = $urandom_range(55, 85);
        end
      endcase
      drain_results();
      apply_config(live, soft_cap, hard, span);
      if (press > 0) hold_token <= hold_token + 1;
      for (int n = 0; n < items; n++) begin
        send_beat(gen_beat(push_pct), 1'b0, '0);
        if (press > 0) begin
          press--;
          g = 0;
        end else if (tx_calm > 0) begin
          tx_calm--;
          g = 0;
        end else begin
          g = gap_len();
          if ($urandom_range(0, 99) < 4) tx_calm = $urandom_range(10, 40);
        end
        pause_sender(g);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== keyframe_aware_drop_queue_unit.f =====
sv/kdq_pkg.sv
sv/kdq_ram.sv
sv/kdq_ctrl.sv
sv/kdq_dp.sv
sv/keyframe_aware_drop_queue_unit.sv
test/tb.sv
